// ----- rtl/urdd_pkg.sv -----
package urdd_pkg;

  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIST_W     = 10;
  localparam int SEG_W      = 8;
  localparam int SEL_W      = 4;

  localparam logic [DIST_W-1:0] DIST_MAX = 10'd1023;

  localparam logic [CFG_IDX_W-1:0] REG_TRIG_PHASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_DWELL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_DWELL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL       = 3'd4;

  localparam logic [TICK_W-1:0] RST_TRIG_PHASE  = 16'd20;
  localparam logic [TICK_W-1:0] RST_DIVISOR     = 16'd116;
  localparam logic [TICK_W-1:0] RST_SHORT_DWELL = 16'd4000;
  localparam logic [TICK_W-1:0] RST_LONG_DWELL  = 16'd6000;
  localparam logic [TICK_W-1:0] RST_TAIL        = 16'd2000;

  typedef enum logic [2:0] {
    PH_TRIG_LOW1 = 3'd0,
    PH_TRIG_HIGH = 3'd1,
    PH_TRIG_LOW2 = 3'd2,
    PH_WAIT_ECHO = 3'd3,
    PH_COUNT     = 3'd4,
    PH_DISPLAY   = 3'd5,
    PH_TAIL      = 3'd6
  } ph_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } st_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic div_start;
    logic div_run;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] v);
    logic [SEG_W-1:0] s;
    case (v)
      4'd0, 4'd10: s = 8'h3F;
      4'd1, 4'd11: s = 8'h06;
      4'd2, 4'd12: s = 8'h5B;
      4'd3, 4'd13: s = 8'h4F;
      4'd4, 4'd14: s = 8'h66;
      4'd5, 4'd15: s = 8'h6D;
      4'd6:        s = 8'h7C;
      4'd7:        s = 8'h07;
      4'd8:        s = 8'h7F;
      4'd9:        s = 8'h67;
      default:     s = 8'h3F;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/urdd_in_if.sv -----
interface urdd_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

// ----- rtl/urdd_out_if.sv -----
interface urdd_out_if;
  logic       valid;
  logic       ready;
  logic       trigger_out;
  logic [7:0] segment_pattern;
  logic [3:0] digit_select;
  logic [9:0] distance_cm;
  logic       distance_valid;

  modport source (output valid, output trigger_out, output segment_pattern,
                  output digit_select, output distance_cm, output distance_valid,
                  input ready);
  modport sink (input valid, input trigger_out, input segment_pattern,
                input digit_select, input distance_cm, input distance_valid,
                output ready);
endinterface

// ----- rtl/urdd_cfg_if.sv -----
interface urdd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/urdd_ctrl.sv -----
module urdd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  urdd_pkg::sts_t sts,
  output urdd_pkg::cmd_t cmd
);
  import urdd_pkg::*;

  st_t state_r;
  st_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else if (sts.out_free) begin
          cmd.step  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/urdd_dp.sv -----
module urdd_dp #(
  parameter int NUM_DIGITS  = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  urdd_pkg::cmd_t                      cmd,
  output urdd_pkg::sts_t                      sts,
  input  logic                                in_echo_level,
  input  logic                                cfg_valid,
  input  logic [urdd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [urdd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_trigger_out,
  output logic [urdd_pkg::SEG_W-1:0]          out_segment_pattern,
  output logic [urdd_pkg::SEL_W-1:0]          out_digit_select,
  output logic [urdd_pkg::DIST_W-1:0]         out_distance_cm,
  output logic                                out_distance_valid
);
  import urdd_pkg::*;

  localparam int DIG_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int CNT_W = $clog2(COUNT_WIDTH);
  localparam int BCD_W = NUM_DIGITS * 4;

  logic [TICK_W-1:0] trig_ticks_r;
  logic [TICK_W-1:0] divisor_r;
  logic [TICK_W-1:0] short_dwell_r;
  logic [TICK_W-1:0] long_dwell_r;
  logic [TICK_W-1:0] tail_r;

  ph_t                               phase_r, phase_nxt;
  logic [TICK_W-1:0]                 ticks_r, ticks_nxt;
  logic [COUNT_WIDTH-1:0]            count_r, count_nxt;
  logic [NUM_DIGITS-1:0][3:0]        digit_r, digit_nxt;
  logic [DIST_W-1:0]                 dist_r, dist_nxt;
  logic [SEG_W-1:0]                  seg_r, seg_nxt;
  logic [SEL_W-1:0]                  sel_r, sel_nxt;
  logic [DIG_W-1:0]                  cur_r, cur_nxt;
  logic                              echo_r;

  logic [COUNT_WIDTH-1:0]            work_r;
  logic [TICK_W-1:0]                 rem_r;
  logic [NUM_DIGITS-1:0][3:0]        bcd_r;
  logic [CNT_W-1:0]                  cnt_r;

  logic                              out_valid_r;
  logic                              out_trig_r;
  logic                              out_dvalid_r;
  logic [SEG_W-1:0]                  out_seg_r;
  logic [SEL_W-1:0]                  out_sel_r;
  logic [DIST_W-1:0]                 out_dist_r;

  logic [TICK_W-1:0]                 limit;
  logic [TICK_W-1:0]                 limit1;
  logic [TICK_W-1:0]                 tick_inc;
  logic                              done;
  logic                              load_en;
  logic [DIG_W-1:0]                  load_idx;
  logic [32:0]                       q_ext;

  logic [TICK_W-1:0]                 dvs;
  logic [TICK_W:0]                   rem2;
  logic [TICK_W:0]                   diff;
  logic                              qbit;
  logic [NUM_DIGITS-1:0][3:0]        bcd_adj;
  logic [BCD_W-1:0]                  bcd_flat;
  logic [BCD_W-1:0]                  bcd_shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ticks_r  <= RST_TRIG_PHASE;
      divisor_r     <= RST_DIVISOR;
      short_dwell_r <= RST_SHORT_DWELL;
      long_dwell_r  <= RST_LONG_DWELL;
      tail_r        <= RST_TAIL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRIG_PHASE:  trig_ticks_r  <= cfg_data;
        REG_DIVISOR:     divisor_r     <= cfg_data;
        REG_SHORT_DWELL: short_dwell_r <= cfg_data;
        REG_LONG_DWELL:  long_dwell_r  <= cfg_data;
        REG_TAIL:        tail_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase_r)
      PH_DISPLAY: limit = cur_r[0] ? short_dwell_r : long_dwell_r;
      PH_TAIL:    limit = tail_r;
      default:    limit = trig_ticks_r;
    endcase
    limit1   = (limit == '0) ? TICK_W'(1) : limit;
    tick_inc = ticks_r + TICK_W'(1);
    done     = (tick_inc >= limit1);
    q_ext    = 33'(work_r);
  end

  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    count_nxt = count_r;
    digit_nxt = digit_r;
    dist_nxt  = dist_r;
    seg_nxt   = seg_r;
    sel_nxt   = sel_r;
    cur_nxt   = cur_r;
    load_en   = 1'b0;
    load_idx  = cur_r;
    if (cmd.step) begin
      case (phase_r)
        PH_TRIG_LOW1: begin
          ticks_nxt = done ? '0 : tick_inc;
          if (done) phase_nxt = PH_TRIG_HIGH;
        end
        PH_TRIG_HIGH: begin
          ticks_nxt = done ? '0 : tick_inc;
          if (done) phase_nxt = PH_TRIG_LOW2;
        end
        PH_TRIG_LOW2: begin
          ticks_nxt = done ? '0 : tick_inc;
          if (done) phase_nxt = PH_WAIT_ECHO;
        end
        PH_WAIT_ECHO: begin
          if (echo_r) begin
            count_nxt = '0;
            phase_nxt = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (echo_r) count_nxt = count_r + COUNT_WIDTH'(1);
        end
        PH_DISPLAY: begin
          ticks_nxt = done ? '0 : tick_inc;
          if (done) begin
            if (cur_r != '0) begin
              load_en  = 1'b1;
              load_idx = cur_r - DIG_W'(1);
            end else if (tail_r == '0) begin
              phase_nxt = PH_TRIG_LOW1;
            end else begin
              phase_nxt = PH_TAIL;
            end
          end
        end
        PH_TAIL: begin
          ticks_nxt = done ? '0 : tick_inc;
          if (done) phase_nxt = PH_TRIG_LOW1;
        end
        default: begin
          phase_nxt = PH_TRIG_LOW1;
          ticks_nxt = '0;
        end
      endcase
    end else if (cmd.finish) begin
      digit_nxt = bcd_r;
      dist_nxt  = (q_ext > 33'(DIST_MAX)) ? DIST_MAX : DIST_W'(q_ext);
      load_en   = 1'b1;
      load_idx  = DIG_W'(NUM_DIGITS - 1);
    end
    if (load_en) begin
      cur_nxt   = load_idx;
      seg_nxt   = seg_of(digit_nxt[load_idx]);
      sel_nxt   = SEL_W'(1) << load_idx;
      phase_nxt = PH_DISPLAY;
      ticks_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TRIG_LOW1;
      ticks_r <= '0;
      count_r <= '0;
      digit_r <= '0;
      dist_r  <= '0;
      seg_r   <= '0;
      sel_r   <= '0;
      cur_r   <= DIG_W'(NUM_DIGITS - 1);
    end else begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      count_r <= count_nxt;
      digit_r <= digit_nxt;
      dist_r  <= dist_nxt;
      seg_r   <= seg_nxt;
      sel_r   <= sel_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      echo_r <= in_echo_level;
    end
  end

  always_comb begin
    dvs  = (divisor_r == '0) ? TICK_W'(1) : divisor_r;
    rem2 = {rem_r, work_r[COUNT_WIDTH-1]};
    diff = rem2 - {1'b0, dvs};
    qbit = (rem2 >= {1'b0, dvs});
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    bcd_flat  = bcd_adj;
    bcd_shift = {bcd_flat[BCD_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      cnt_r <= '0;
    end else if (cmd.div_run) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      work_r <= count_r;
      rem_r  <= '0;
      bcd_r  <= '0;
    end else if (cmd.div_run) begin
      work_r <= {work_r[COUNT_WIDTH-2:0], qbit};
      rem_r  <= qbit ? diff[TICK_W-1:0] : rem2[TICK_W-1:0];
      bcd_r  <= bcd_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step || cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step || cmd.finish) begin
      out_trig_r   <= (phase_r == PH_TRIG_HIGH);
      out_seg_r    <= seg_nxt;
      out_sel_r    <= sel_nxt;
      out_dist_r   <= dist_nxt;
      out_dvalid_r <= cmd.finish;
    end
  end

  assign sts.need_div = (phase_r == PH_COUNT) && !echo_r;
  assign sts.div_last = (cnt_r == CNT_W'(COUNT_WIDTH - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_trigger_out     = out_trig_r;
  assign out_segment_pattern = out_seg_r;
  assign out_digit_select    = out_sel_r;
  assign out_distance_cm     = out_dist_r;
  assign out_distance_valid  = out_dvalid_r;

endmodule

// ----- rtl/ultrasonic_ranger_with_digit_display_unit.sv -----
// channel | dir | handshake    | payload
// in_ch   | in  | valid/ready  | echo_level (one timer tick)
// out_ch  | out | valid/ready  | trigger_out, segment_pattern, digit_select,
//         |     |              | distance_cm, distance_valid
// cfg_ch  | in  | valid/ready  | index (3), data (16); ready always high
//
// Each tick is taken in ST_IDLE, then steps the sequencer in ST_EXEC.
// The tick that ends the echo goes on through ST_DIV, where the
// restoring divider gives one quotient bit per cycle, feeding the BCD converter, then ST_FIN.
// A finished result waits in the output register; the next tick is taken
// meanwhile and holds in its step cycle until that register frees.
// rst_n is synchronous, active low, and loads the register defaults.
module ultrasonic_ranger_with_digit_display_unit #(
  parameter int NUM_DIGITS  = 4,
  parameter int COUNT_WIDTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  urdd_in_if.sink   in_ch,
  urdd_out_if.source out_ch,
  urdd_cfg_if.sink  cfg_ch
);
  import urdd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  urdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  urdd_dp #(
    .NUM_DIGITS  (NUM_DIGITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_echo_level       (in_ch.echo_level),
    .cfg_valid           (cfg_ch.valid),
    .cfg_index           (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_trigger_out     (out_ch.trigger_out),
    .out_segment_pattern (out_ch.segment_pattern),
    .out_digit_select    (out_ch.digit_select),
    .out_distance_cm     (out_ch.distance_cm),
    .out_distance_valid  (out_ch.distance_valid)
  );

endmodule
